FILE: design/vpbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the volume pixel binning sum core.
// No dependencies; imported by volume_pixel_binning_sum_core.
package vpbs_pkg;

    // Sum width and configuration port geometry
    localparam int SUM_BITS    = 28;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int M_TDATA_W   = ((2 * SUM_BITS + 7) / 8) * 8;

    // Register field widths
    localparam int LW_W  = 11;
    localparam int LC_W  = 11;
    localparam int FC_W  = 9;
    localparam int BIN_W = 5;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COUNT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_X        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_Y        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_Z        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPLEX_MODE = 3'd6;

    // Register reset values
    localparam logic [LW_W-1:0]  LW_RESET  = 11'd64;
    localparam logic [LC_W-1:0]  LC_RESET  = 11'd64;
    localparam logic [FC_W-1:0]  FC_RESET  = 9'd1;
    localparam logic [BIN_W-1:0] BX_RESET  = 5'd4;
    localparam logic [BIN_W-1:0] BY_RESET  = 5'd4;
    localparam logic [BIN_W-1:0] BZ_RESET  = 5'd1;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam int FIFO_ROOM  = FIFO_DEPTH - 2;

    typedef struct packed {
        logic                       last_of_volume;
        logic signed [SUM_BITS-1:0] sum_b;
        logic signed [SUM_BITS-1:0] sum_a;
    } result_t;

endpackage

FILE: design/volume_pixel_binning_sum_core.sv
`timescale 1ns / 1ps
// Volume pixel binning: partial-sum plane in a synchronous RAM, read-modify-write.
// Depends on vpbs_pkg.
//
// Throughput: one pixel per cycle while s_tready is high, set by the RAM read-modify-write
// loop (a forwarding register covers back-to-back hits on the same entry).
// A result passes through the stage 1 request register into the result queue, whose count
// drives m_tvalid. Bin limits are derived by a shared restoring divider after reset and
// after every register write, with s_tready low until they are done.
// Reset (aresetn low, synchronous) clears positions, the result queue and registers to
// their defaults; the partial-sum plane is not cleared.
module volume_pixel_binning_sum_core #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int MAX_LINE_COUNT = 1024,
    parameter int MAX_FRAMES     = 256,
    parameter int MAX_BIN        = 16,
    parameter int PLANE_STORE    = 4096,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // Pixel requests
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]           s_tdata,   // value_a, value_b
    // Binned results
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [vpbs_pkg::M_TDATA_W-1:0]               m_tdata,   // sum_a, sum_b
    output logic                                         m_tlast,   // last_of_volume
    // Register writes
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [vpbs_pkg::CFG_INDEX_W-1:0]             cfg_index,
    input  logic [vpbs_pkg::CFG_DATA_W-1:0]              cfg_data
);
    import vpbs_pkg::*;

    localparam int XW  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int YW  = $clog2(MAX_LINE_COUNT + 1);
    localparam int ZW  = $clog2(MAX_FRAMES + 1);
    localparam int BW  = $clog2(MAX_BIN + 1);
    localparam int AW  = (PLANE_STORE > 1) ? $clog2(PLANE_STORE) : 1;
    localparam int DW  = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
    localparam int DVB = (MAX_BIN > PLANE_STORE) ? MAX_BIN : PLANE_STORE;
    localparam int DVW = $clog2(DVB + 1);
    localparam int SW  = $clog2(DW + 1);

    // Limit calculation sequencer
    localparam logic [1:0] CALC_IDLE = 2'd0;
    localparam logic [1:0] CALC_LOAD = 2'd1;
    localparam logic [1:0] CALC_DIV  = 2'd2;
    localparam logic [1:0] CALC_MUL  = 2'd3;

    localparam logic [1:0] SEL_X     = 2'd0;
    localparam logic [1:0] SEL_Y     = 2'd1;
    localparam logic [1:0] SEL_Z     = 2'd2;
    localparam logic [1:0] SEL_STORE = 2'd3;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [LW_W-1:0]  cfg_lw_reg;
    logic [LC_W-1:0]  cfg_lc_reg;
    logic [FC_W-1:0]  cfg_fc_reg;
    logic [BIN_W-1:0] cfg_bx_reg, cfg_by_reg, cfg_bz_reg;
    logic             cfg_cm_reg;
    logic             cfg_hit;

    assign cfg_ready = 1'b1;

    always_comb begin
        unique case (cfg_index)
            REG_LINE_WIDTH, REG_LINE_COUNT, REG_FRAME_COUNT, REG_BIN_X,
            REG_BIN_Y, REG_BIN_Z, REG_COMPLEX_MODE: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_lw_reg <= LW_RESET;
            cfg_lc_reg <= LC_RESET;
            cfg_fc_reg <= FC_RESET;
            cfg_bx_reg <= BX_RESET;
            cfg_by_reg <= BY_RESET;
            cfg_bz_reg <= BZ_RESET;
            cfg_cm_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LINE_WIDTH:   cfg_lw_reg <= cfg_data[LW_W-1:0];
                REG_LINE_COUNT:   cfg_lc_reg <= cfg_data[LC_W-1:0];
                REG_FRAME_COUNT:  cfg_fc_reg <= cfg_data[FC_W-1:0];
                REG_BIN_X:        cfg_bx_reg <= cfg_data[BIN_W-1:0];
                REG_BIN_Y:        cfg_by_reg <= cfg_data[BIN_W-1:0];
                REG_BIN_Z:        cfg_bz_reg <= cfg_data[BIN_W-1:0];
                REG_COMPLEX_MODE: cfg_cm_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamped sizes: zero reads as one, large values saturate
    logic [XW-1:0] lw_c;
    logic [YW-1:0] lc_c;
    logic [ZW-1:0] fc_c;
    logic [BW-1:0] bx_c, by_c, bz_c;

    always_comb begin
        if (cfg_lw_reg == '0)                           lw_c = XW'(1);
        else if (32'(cfg_lw_reg) > 32'(MAX_LINE_WIDTH)) lw_c = XW'(MAX_LINE_WIDTH);
        else                                            lw_c = XW'(cfg_lw_reg);
        if (cfg_lc_reg == '0)                           lc_c = YW'(1);
        else if (32'(cfg_lc_reg) > 32'(MAX_LINE_COUNT)) lc_c = YW'(MAX_LINE_COUNT);
        else                                            lc_c = YW'(cfg_lc_reg);
        if (cfg_fc_reg == '0)                           fc_c = ZW'(1);
        else if (32'(cfg_fc_reg) > 32'(MAX_FRAMES))     fc_c = ZW'(MAX_FRAMES);
        else                                            fc_c = ZW'(cfg_fc_reg);
        if (cfg_bx_reg == '0)                           bx_c = BW'(1);
        else if (32'(cfg_bx_reg) > 32'(MAX_BIN))        bx_c = BW'(MAX_BIN);
        else                                            bx_c = BW'(cfg_bx_reg);
        if (cfg_by_reg == '0)                           by_c = BW'(1);
        else if (32'(cfg_by_reg) > 32'(MAX_BIN))        by_c = BW'(MAX_BIN);
        else                                            by_c = BW'(cfg_by_reg);
        if (cfg_bz_reg == '0)                           bz_c = BW'(1);
        else if (32'(cfg_bz_reg) > 32'(MAX_BIN))        bz_c = BW'(MAX_BIN);
        else                                            bz_c = BW'(cfg_bz_reg);
    end

    // ---------------------------------------------------------------
    // Limit calculation: shared restoring divider; each bin limit takes one multiply
    // ---------------------------------------------------------------
    logic [1:0]     calc_state_reg, calc_sel_reg;
    logic [DW-1:0]  quo_reg;
    logic [DVW-1:0] rem_reg;
    logic [SW-1:0]  step_reg;
    logic [XW-1:0]  xlim_reg, out_w_reg;
    logic [YW-1:0]  ylim_reg;
    logic [ZW-1:0]  zlim_reg;
    logic [AW-1:0]  out_w_mod_reg;

    logic [DW-1:0]  dvd;
    logic [DVW-1:0] dvs;
    logic [DVW:0]   trial;
    logic           trial_ge;

    always_comb begin
        case (calc_sel_reg)
            SEL_X:   begin dvd = DW'(lw_c);      dvs = DVW'(bx_c);        end
            SEL_Y:   begin dvd = DW'(lc_c);      dvs = DVW'(by_c);        end
            SEL_Z:   begin dvd = DW'(fc_c);      dvs = DVW'(bz_c);        end
            default: begin dvd = DW'(out_w_reg); dvs = DVW'(PLANE_STORE); end
        endcase
        trial    = {rem_reg, quo_reg[DW-1]};
        trial_ge = trial >= {1'b0, dvs};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calc_state_reg <= CALC_LOAD;
            calc_sel_reg   <= SEL_X;
        end else if (cfg_hit) begin
            calc_state_reg <= CALC_LOAD;
            calc_sel_reg   <= SEL_X;
        end else begin
            unique case (calc_state_reg)
                CALC_IDLE: ;
                CALC_LOAD: calc_state_reg <= CALC_DIV;
                CALC_DIV: begin
                    if (step_reg == SW'(DW - 1)) calc_state_reg <= CALC_MUL;
                end
                CALC_MUL: begin
                    if (calc_sel_reg == SEL_STORE) begin
                        calc_state_reg <= CALC_IDLE;
                    end else begin
                        calc_state_reg <= CALC_LOAD;
                        calc_sel_reg   <= calc_sel_reg + 2'd1;
                    end
                end
                default: calc_state_reg <= CALC_IDLE;
            endcase
        end
    end

    // Divider datapath and derived limits
    always_ff @(posedge aclk) begin
        if (calc_state_reg == CALC_LOAD) begin
            quo_reg  <= dvd;
            rem_reg  <= '0;
            step_reg <= '0;
        end else if (calc_state_reg == CALC_DIV) begin
            quo_reg  <= DW'({quo_reg, trial_ge});
            rem_reg  <= trial_ge ? DVW'(trial - {1'b0, dvs}) : DVW'(trial);
            step_reg <= step_reg + SW'(1);
        end
        if (calc_state_reg == CALC_MUL) begin
            case (calc_sel_reg)
                SEL_X: begin
                    xlim_reg  <= XW'(quo_reg * dvs);
                    out_w_reg <= XW'(quo_reg);
                end
                SEL_Y:   ylim_reg      <= YW'(quo_reg * dvs);
                SEL_Z:   zlim_reg      <= ZW'(quo_reg * dvs);
                default: out_w_mod_reg <= rem_reg[AW-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Raster position tracking (at pixel request)
    // ---------------------------------------------------------------
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [ZW-1:0] frm_reg, frm_next;
    logic [BW-1:0] phx_reg, phx_next, phy_reg, phy_next, phz_reg, phz_next;
    logic [AW-1:0] oidx_reg, oidx_next, rb_reg, rb_next;
    logic [AW:0]   rb_sum;
    logic          in_accept, in_range, pix_first, pix_last, pix_lastvol;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  push, pop;

    assign s_tready  = (calc_state_reg == CALC_IDLE)
                       && ((cnt_reg + FIFO_CNT_W'(push)) <= FIFO_CNT_W'(FIFO_ROOM));
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        in_range    = (col_reg < xlim_reg) && (row_reg < ylim_reg) && (frm_reg < zlim_reg);
        pix_first   = (phx_reg == '0) && (phy_reg == '0) && (phz_reg == '0);
        pix_last    = ((BW+1)'(phx_reg) + 1'b1 == (BW+1)'(bx_c))
                      && ((BW+1)'(phy_reg) + 1'b1 == (BW+1)'(by_c))
                      && ((BW+1)'(phz_reg) + 1'b1 == (BW+1)'(bz_c));
        pix_lastvol = ((XW+1)'(col_reg) + 1'b1 == (XW+1)'(xlim_reg))
                      && ((YW+1)'(row_reg) + 1'b1 == (YW+1)'(ylim_reg))
                      && ((ZW+1)'(frm_reg) + 1'b1 == (ZW+1)'(zlim_reg));

        col_next  = col_reg;
        row_next  = row_reg;
        frm_next  = frm_reg;
        phx_next  = phx_reg;
        phy_next  = phy_reg;
        phz_next  = phz_reg;
        oidx_next = oidx_reg;
        rb_next   = rb_reg;
        rb_sum    = (AW+1)'(rb_reg) + (AW+1)'(out_w_mod_reg);

        if (in_accept) begin
            // column and horizontal phase
            col_next = col_reg + XW'(1);
            phx_next = phx_reg + BW'(1);
            if (phx_next >= bx_c) begin
                phx_next  = '0;
                oidx_next = (oidx_reg == AW'(PLANE_STORE - 1)) ? '0 : oidx_reg + AW'(1);
            end
            // end of a row
            if (col_next >= lw_c) begin
                col_next = '0;
                phx_next = '0;
                row_next = row_reg + YW'(1);
                phy_next = phy_reg + BW'(1);
                if (phy_next >= by_c) begin
                    phy_next = '0;
                    rb_next  = (rb_sum >= (AW+1)'(PLANE_STORE))
                               ? AW'(rb_sum - (AW+1)'(PLANE_STORE)) : AW'(rb_sum);
                end
                // end of a frame
                if (row_next >= lc_c) begin
                    row_next = '0;
                    phy_next = '0;
                    rb_next  = '0;
                    frm_next = frm_reg + ZW'(1);
                    phz_next = phz_reg + BW'(1);
                    if (phz_next >= bz_c) phz_next = '0;
                    if (frm_next >= fc_c) begin
                        frm_next = '0;
                        phz_next = '0;
                    end
                end
                oidx_next = rb_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            frm_reg  <= '0;
            phx_reg  <= '0;
            phy_reg  <= '0;
            phz_reg  <= '0;
            oidx_reg <= '0;
            rb_reg   <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            frm_reg  <= frm_next;
            phx_reg  <= phx_next;
            phy_reg  <= phy_next;
            phz_reg  <= phz_next;
            oidx_reg <= oidx_next;
            rb_reg   <= rb_next;
        end
    end

    // ---------------------------------------------------------------
    // Partial-sum plane: read at request, add and write back next cycle
    // ---------------------------------------------------------------
    logic [2*SUM_BITS-1:0] plane_mem [PLANE_STORE];
    logic [2*SUM_BITS-1:0] rd_data_reg, wr_data_reg, base_word;
    logic [AW-1:0]         wr_idx_reg, p1_idx_reg;
    logic                  wr_valid_reg, p1_valid_reg;
    logic                  p1_first_reg, p1_last_reg, p1_lastvol_reg;
    logic [SUM_BITS-1:0]   p1_va_reg, p1_vb_reg, sum_a, sum_b;

    // Stage 1 request register
    always_ff @(posedge aclk) begin
        if (!aresetn) p1_valid_reg <= 1'b0;
        else          p1_valid_reg <= in_accept && in_range;
        p1_idx_reg     <= oidx_reg;
        p1_first_reg   <= pix_first;
        p1_last_reg    <= pix_last;
        p1_lastvol_reg <= pix_lastvol;
        p1_va_reg      <= SUM_BITS'($signed(s_tdata[SAMPLE_BITS-1:0]));
        p1_vb_reg      <= cfg_cm_reg
                          ? SUM_BITS'($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])) : '0;
    end

    // Forward the write that landed on the same edge as this entry's read
    always_comb begin
        base_word = (wr_valid_reg && wr_idx_reg == p1_idx_reg) ? wr_data_reg : rd_data_reg;
        sum_a = (p1_first_reg ? '0 : base_word[SUM_BITS-1:0]) + p1_va_reg;
        sum_b = (p1_first_reg ? '0 : base_word[2*SUM_BITS-1:SUM_BITS]) + p1_vb_reg;
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) plane_mem[p1_idx_reg] <= {sum_b, sum_a};
        rd_data_reg <= plane_mem[oidx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) wr_valid_reg <= 1'b0;
        else          wr_valid_reg <= p1_valid_reg;
        wr_idx_reg  <= p1_idx_reg;
        wr_data_reg <= {sum_b, sum_a};
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    result_t               res_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    result_t               head;

    assign push = p1_valid_reg && p1_last_reg;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            cnt_reg <= cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_mem[wr_ptr_reg] <= '{last_of_volume: p1_lastvol_reg,
                                     sum_b: sum_b, sum_a: sum_a};
        end
    end

    assign head     = res_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = M_TDATA_W'({head.sum_b, head.sum_a});
    assign m_tlast  = head.last_of_volume;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (cnt_reg != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result pushed into a full queue");

    a_limits_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (calc_state_reg == CALC_IDLE) |->
            ((xlim_reg <= lw_c) && (ylim_reg <= lc_c) && (zlim_reg <= fc_c)))
        else $error("bin limit exceeds clamped size");

    a_stage_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> $past(in_accept))
        else $error("plane update without a pixel request");

endmodule

FILE: bench/volume_pixel_binning_sum_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for volume_pixel_binning_sum_core: drives pixel requests and
// register writes, predicts every binned sum and checks each result in order.
// Depends on vpbs_pkg and the core itself.
module volume_pixel_binning_sum_core_tb;
    import vpbs_pkg::*;

    localparam int unsigned MAX_LINE_WIDTH = 1024;
    localparam int unsigned MAX_LINE_COUNT = 1024;
    localparam int unsigned MAX_FRAMES     = 256;
    localparam int unsigned MAX_BIN        = 16;
    localparam int unsigned PLANE_STORE    = 4096;
    localparam int unsigned IDLE_LIMIT     = 2000;  // cycles with no request moving
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned RANDOM_ITEMS   = 120;
    localparam int unsigned RANDOM_RESULTS = 16;
    localparam int unsigned QUIET_FROM     = 60;
    localparam int unsigned MAX_REPORTS    = 100;

    typedef enum int {
        PAT_RANDOM,   // random samples
        PAT_SPLIT,    // value_a left half of each row at minimum, right half at maximum; value_b inverted
        PAT_CORNER    // value_a minimum, value_b maximum everywhere
    } pattern_t;

    // Predicts the binned sums from the accepted pixel and register requests
    class bin_sum_tracker;
        bit [LW_W-1:0]     reg_lw;
        bit [LC_W-1:0]     reg_lc;
        bit [FC_W-1:0]     reg_fc;
        bit [BIN_W-1:0]    reg_bx, reg_by, reg_bz;
        bit                reg_cx;
        bit [SUM_BITS-1:0] plane_a [PLANE_STORE];
        bit [SUM_BITS-1:0] plane_b [PLANE_STORE];
        int unsigned       col, row, frm, ph_x, ph_y, ph_z, out_idx, row_base;
        result_t           expected_sums [$];
        int unsigned       results_due;
        int unsigned       errors;

        function new();
            reg_lw = LW_RESET; reg_lc = LC_RESET; reg_fc = FC_RESET;
            reg_bx = BX_RESET; reg_by = BY_RESET; reg_bz = BZ_RESET;
            reg_cx = 1'b0;
            col = 0; row = 0; frm = 0; ph_x = 0; ph_y = 0; ph_z = 0;
            out_idx = 0; row_base = 0;
            results_due = 0;
            errors = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int unsigned volume_pixels();
            return clamp_size(reg_lw, MAX_LINE_WIDTH) * clamp_size(reg_lc, MAX_LINE_COUNT)
                   * clamp_size(reg_fc, MAX_FRAMES);
        endfunction

        function int unsigned pending();
            return expected_sums.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LINE_WIDTH:   reg_lw = val[LW_W-1:0];
                REG_LINE_COUNT:   reg_lc = val[LC_W-1:0];
                REG_FRAME_COUNT:  reg_fc = val[FC_W-1:0];
                REG_BIN_X:        reg_bx = val[BIN_W-1:0];
                REG_BIN_Y:        reg_by = val[BIN_W-1:0];
                REG_BIN_Z:        reg_bz = val[BIN_W-1:0];
                REG_COMPLEX_MODE: reg_cx = val[0];
                default: ;
            endcase
        endfunction

        // One accepted pixel request: accumulate, maybe emit, then step the raster
        function void note_pixel(logic [31:0] data);
            int unsigned       lw, lc, fc, bx, by, bz, out_w, xlim, ylim, zlim, idx;
            logic [SUM_BITS-1:0] va, vb, sa, sb;
            bit                is_first, is_last;
            result_t           r;
            lw = clamp_size(reg_lw, MAX_LINE_WIDTH);
            lc = clamp_size(reg_lc, MAX_LINE_COUNT);
            fc = clamp_size(reg_fc, MAX_FRAMES);
            bx = clamp_size(reg_bx, MAX_BIN);
            by = clamp_size(reg_by, MAX_BIN);
            bz = clamp_size(reg_bz, MAX_BIN);
            out_w = lw / bx;
            xlim = out_w * bx;
            ylim = (lc / by) * by;
            zlim = (fc / bz) * bz;
            va = {{(SUM_BITS-16){data[15]}}, data[15:0]};
            vb = reg_cx ? {{(SUM_BITS-16){data[31]}}, data[31:16]} : '0;

            if (col < xlim && row < ylim && frm < zlim) begin
                idx = out_idx % PLANE_STORE;
                is_first = (ph_x == 0) && (ph_y == 0) && (ph_z == 0);
                is_last = (ph_x + 1 == bx) && (ph_y + 1 == by) && (ph_z + 1 == bz);
                sa = (is_first ? '0 : plane_a[idx]) + va;
                sb = (is_first ? '0 : plane_b[idx]) + vb;
                plane_a[idx] = sa;
                plane_b[idx] = sb;
                if (is_last) begin
                    r.sum_a = sa;
                    r.sum_b = sb;
                    r.last_of_volume = (col + 1 == xlim) && (row + 1 == ylim)
                                       && (frm + 1 == zlim);
                    expected_sums.push_back(r);
                    results_due++;
                end
            end

            // raster advance: column, then row, then frame
            col++;
            ph_x++;
            if (ph_x >= bx) begin
                ph_x = 0;
                out_idx++;
            end
            if (col >= lw) begin
                col = 0;
                ph_x = 0;
                row++;
                ph_y++;
                if (ph_y >= by) begin
                    ph_y = 0;
                    row_base += out_w;
                end
                if (row >= lc) begin
                    row = 0;
                    ph_y = 0;
                    row_base = 0;
                    frm++;
                    ph_z++;
                    if (ph_z >= bz) ph_z = 0;
                    if (frm >= fc) begin
                        frm = 0;
                        ph_z = 0;
                    end
                end
                out_idx = row_base;
            end
        endfunction

        function void report(string field, longint exp_v, longint got_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
        endfunction

        // One accepted result: compare against the oldest prediction
        function void check_sum(logic [M_TDATA_W-1:0] data, logic tl);
            result_t exp_r;
            logic signed [SUM_BITS-1:0] got_a, got_b;
            got_a = data[SUM_BITS-1:0];
            got_b = data[2*SUM_BITS-1:SUM_BITS];
            if (expected_sums.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result with nothing predicted: sum_a %0d sum_b %0d last %0b",
                           got_a, got_b, tl);
                return;
            end
            exp_r = expected_sums.pop_front();
            if (got_a !== exp_r.sum_a) report("sum_a", exp_r.sum_a, got_a);
            if (got_b !== exp_r.sum_b) report("sum_b", exp_r.sum_b, got_b);
            if (tl !== exp_r.last_of_volume)
                report("last_of_volume", exp_r.last_of_volume, tl);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bin_sum_tracker sums = new();
    bit             quiet = 1'b0;          // final stretch: no idling on either side
    bit             hold_results = 1'b0;   // asks the receiver for one long hold-off
    bit             holding = 1'b0;
    int unsigned    idle_cycles = 0;

    always #6 aclk = ~aclk;

    volume_pixel_binning_sum_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Observe every request that moves
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sums.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sums.note_pixel(s_tdata);
            if (m_tvalid && m_tready) sums.check_sum(m_tdata, m_tlast);
        end
    end

    // Watchdog on cycles with no request moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stalls, ready stretches and one long hold-off
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_results) begin
                m_tready <= 1'b0;
                holding = 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
                holding = 1'b0;
                hold_results = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    // Register write; valid stays high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input int unsigned lw, lc, fc, bx, by, bz, cx);
        write_reg(REG_LINE_WIDTH, lw);
        write_reg(REG_LINE_COUNT, lc);
        write_reg(REG_FRAME_COUNT, fc);
        write_reg(REG_BIN_X, bx);
        write_reg(REG_BIN_Y, by);
        write_reg(REG_BIN_Z, bz);
        write_reg(REG_COMPLEX_MODE, cx);
        close_cfg();
    endtask

    // Wait for every predicted result, then let the pipeline run dry
    task automatic settle();
        @(posedge aclk);
        while (sums.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stream n pixel requests; valid drops only for gaps and after the last one
    task automatic send_pixels(input int unsigned n, input pattern_t pat,
                               input bit allow_gaps);
        int unsigned i, col, lw;
        logic [15:0] a, b;
        lw  = sums.clamp_size(sums.reg_lw, MAX_LINE_WIDTH);
        col = 0;
        for (i = 0; i < n; i++) begin
            case (pat)
                PAT_SPLIT:  a = (col < lw / 2) ? 16'h8000 : 16'h7FFF;
                PAT_CORNER: a = 16'h8000;
                default:    a = 16'($urandom);
            endcase
            b = (pat == PAT_RANDOM) ? 16'($urandom) : ~a;
            col = (col + 1 == lw) ? 0 : col + 1;
            s_tvalid <= 1'b1;
            s_tdata  <= {b, a};
            do @(posedge aclk); while (!s_tready);
            if (i + 1 < n && allow_gaps && !quiet && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    function automatic int unsigned pick_bin(input int unsigned hi);
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 16);
        return $urandom_range(1, hi);
    endfunction

    initial begin
        int unsigned rand_items, base_results, vols, n, v;
        rand_items = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sample extremes, both components
        configure(4, 2, 1, 2, 2, 1, 1);
        send_pixels(sums.volume_pixels(), PAT_SPLIT, 1'b1);
        settle();

        // real mode: value_b ignored, 3D bins with remainder rows and columns
        configure(7, 4, 3, 3, 3, 2, 0);
        send_pixels(sums.volume_pixels(), PAT_RANDOM, 1'b1);
        settle();

        // bin wider than the line: every pixel dropped
        configure(3, 2, 1, 4, 1, 1, 1);
        send_pixels(sums.volume_pixels(), PAT_RANDOM, 1'b1);
        settle();

        // zero sizes and bins read as one, frame count and bin_z saturate
        configure(0, 0, 511, 0, 0, 31, 1);
        send_pixels(sums.volume_pixels(), PAT_RANDOM, 1'b1);
        settle();

        // line width and bin_x saturate, extreme samples summed over the widest bin
        configure(2047, 1, 1, 31, 1, 1, 1);
        send_pixels(sums.volume_pixels(), PAT_CORNER, 1'b1);
        settle();

        // registers changed in mid volume: frame count shrinks to the current frame index
        configure(4, 4, 4, 2, 2, 1, 1);
        send_pixels(32, PAT_RANDOM, 1'b1);
        settle();
        write_reg(REG_COMPLEX_MODE, 0);
        write_reg(REG_FRAME_COUNT, 2);
        close_cfg();
        send_pixels(16, PAT_RANDOM, 1'b1);
        settle();

        // long receiver hold-off while pixels keep coming
        configure(8, 8, 1, 1, 1, 1, 1);
        hold_results = 1'b1;
        while (!holding) @(posedge aclk);
        send_pixels(sums.volume_pixels(), PAT_RANDOM, 1'b0);
        settle();

        // random volumes, mostly small
        base_results = sums.results_due;
        while (rand_items < RANDOM_ITEMS || sums.results_due - base_results < RANDOM_RESULTS)
        begin
            configure($urandom_range(1, 20), $urandom_range(1, 10), $urandom_range(1, 3),
                      pick_bin(4), pick_bin(4), pick_bin(3), $urandom_range(0, 1));
            vols = $urandom_range(1, 2);
            for (v = 0; v < vols; v++) begin
                n = sums.volume_pixels();
                send_pixels(n, PAT_RANDOM, $urandom_range(0, 2) != 0);
                rand_items += n;
                if (rand_items >= QUIET_FROM) quiet = 1'b1;
            end
            settle();
        end

        repeat (20) @(posedge aclk);
        if (sums.errors == 0 && sums.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
design/vpbs_pkg.sv
design/volume_pixel_binning_sum_core.sv
bench/volume_pixel_binning_sum_core_tb.sv
